@@ sv/lsfs_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfs_pkg
// Shared types and constants of the LED strip frame serializer: command
// codes, register indexes, frame byte constants and the job queue entry.
// ----------------------------------------------------------------------------
package lsfs_pkg;

	typedef enum logic [1:0] {
		CMD_WR_MASK = 2'd0,
		CMD_WR_LED  = 2'd1,
		CMD_RD_MASK = 2'd2,
		CMD_RD_LED  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_ON_BRIGHT  = 3'd0;
	localparam logic [2:0] REG_OFF_BRIGHT = 3'd1;
	localparam logic [2:0] REG_BLUE       = 3'd2;
	localparam logic [2:0] REG_GREEN      = 3'd3;
	localparam logic [2:0] REG_RED        = 3'd4;

	localparam logic [4:0] ON_BRIGHT_RESET  = 5'd30;
	localparam logic [4:0] OFF_BRIGHT_RESET = 5'd0;
	localparam logic [7:0] LEVEL_RESET      = 8'd100;
	localparam logic [7:0] MASK_RESET       = 8'hFF;

	localparam logic [7:0] BRIGHT_PREFIX = 8'hE0;
	localparam logic [7:0] START_BYTE    = 8'h00;
	localparam logic [7:0] END_BYTE      = 8'hFF;

	localparam int QUEUE_DEPTH = 2;

	// One classified request: a read reply value, or the mask for a frame.
	typedef struct packed {
		logic       is_read;
		logic [7:0] value;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [4:0] on_bright;
		logic [4:0] off_bright;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} cfg_t;

endpackage

@@ sv/lsfs_front.sv @@
// ----------------------------------------------------------------------------
// lsfs_front
// Accepts command requests, keeps the LED mask and turns each request into
// a job for the back end: a frame with the updated mask, or a read reply.
// ----------------------------------------------------------------------------
module lsfs_front import lsfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [2:0] led_index,
	input  logic       led_on,
	input  logic [7:0] mask_value,
	input  q_status_t  q_status,
	output logic       push,
	output job_t       push_job
);

	logic [7:0] mask_q;
	logic [7:0] next_mask;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		next_mask        = mask_q;
		push_job.is_read = 1'b0;
		push_job.value   = mask_q;
		case (cmd_t'(cmd))
			CMD_WR_MASK: begin
				next_mask      = mask_value;
				push_job.value = mask_value;
			end
			CMD_WR_LED: begin
				next_mask[led_index] = led_on;
				push_job.value       = next_mask;
			end
			CMD_RD_MASK: begin
				push_job.is_read = 1'b1;
				push_job.value   = mask_q;
			end
			CMD_RD_LED: begin
				push_job.is_read = 1'b1;
				push_job.value   = {7'd0, mask_q[led_index]};
			end
			default: begin
				push_job.is_read = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (push) begin
			mask_q <= next_mask;
		end
	end

endmodule

@@ sv/lsfs_queue.sv @@
// ----------------------------------------------------------------------------
// lsfs_queue
// Short job queue between the front and back ends so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module lsfs_queue import lsfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      pop_job,
	output q_status_t q_status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign q_status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_job        = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("job popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ sv/lsfs_back.sv @@
// ----------------------------------------------------------------------------
// lsfs_back
// Takes jobs from the queue and drives the output register: one reply for a
// read, or for a write the whole frame, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsfs_back import lsfs_pkg::*; #(
	parameter int NUM_LEDS         = 8,
	parameter int FRAME_MARK_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  q_status_t  q_status,
	input  job_t       pop_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_read_reply,
	output logic [7:0] read_value,
	output logic [7:0] frame_byte,
	output logic       frame_last
);

	localparam int FRAME_LEN = 2 * FRAME_MARK_BYTES + 4 * NUM_LEDS;
	localparam int LED_END   = FRAME_MARK_BYTES + 4 * NUM_LEDS;
	localparam int CNT_W     = $clog2(FRAME_LEN);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FRAME = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             is_read_reply_q;
	logic [7:0]       read_value_q;
	logic [7:0]       frame_byte_q;
	logic             frame_last_q;
	logic [7:0]       snap_mask_q;

	logic             load;
	logic             frame_end;
	logic [CNT_W-1:0] led_pos;
	logic [2:0]       led_sel;
	logic             lit;
	logic [7:0]       led_byte;
	logic [7:0]       byte_d;

	assign load      = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && load && !q_status.empty;
	assign frame_end = (cnt_q == CNT_W'(FRAME_LEN - 1));

	// Byte position inside the LED section; four bytes per LED, top LED first.
	assign led_pos = cnt_q - CNT_W'(FRAME_MARK_BYTES);
	assign led_sel = 3'(NUM_LEDS - 1) - 3'(led_pos >> 2);
	assign lit     = snap_mask_q[led_sel];

	always_comb begin
		case (led_pos[1:0])
			2'd0:    led_byte = BRIGHT_PREFIX
			                    | {3'd0, (lit ? cfg.on_bright : cfg.off_bright)};
			2'd1:    led_byte = cfg.blue;
			2'd2:    led_byte = cfg.green;
			default: led_byte = cfg.red;
		endcase
		if (cnt_q < CNT_W'(FRAME_MARK_BYTES)) begin
			byte_d = START_BYTE;
		end else if (cnt_q < CNT_W'(LED_END)) begin
			byte_d = led_byte;
		end else begin
			byte_d = END_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						if (!pop_job.is_read) begin
							state_q <= ST_FRAME;
							cnt_q   <= CNT_W'(1);
						end
					end else if (load) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_FRAME: begin
					if (load) begin
						out_valid_q <= 1'b1;
						if (frame_end) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			// first frame byte goes out with the pop itself
			is_read_reply_q <= pop_job.is_read;
			read_value_q    <= pop_job.is_read ? pop_job.value : 8'd0;
			frame_byte_q    <= pop_job.is_read ? 8'd0 : START_BYTE;
			frame_last_q    <= 1'b0;
			snap_mask_q     <= pop_job.value;
		end else if ((state_q == ST_FRAME) && load) begin
			is_read_reply_q <= 1'b0;
			read_value_q    <= 8'd0;
			frame_byte_q    <= byte_d;
			frame_last_q    <= frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_read_reply = is_read_reply_q;
	assign read_value    = read_value_q;
	assign frame_byte    = frame_byte_q;
	assign frame_last    = frame_last_q;

`ifndef SYNTH
	a_frame_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAME) |-> (cnt_q != '0))
		else $error("frame sequencer at byte zero");
	a_last_is_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_last_q) |-> (!is_read_reply_q && frame_byte_q == END_BYTE))
		else $error("last flag on a byte other than an end byte");
	a_end_sets_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FRAME) && load && frame_end) |=> (out_valid_q && frame_last_q
		&& state_q == ST_IDLE))
		else $error("frame end did not flag last byte");
	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_read_reply_q) |-> (frame_byte_q == 8'd0 && !frame_last_q))
		else $error("read reply carries frame fields");
`endif

endmodule

@@ sv/led_strip_frame_serializer_unit.sv @@
// ----------------------------------------------------------------------------
// led_strip_frame_serializer_unit
// Keeps an on/off mask for a strip of LEDs and emits a serial LED frame for
// every mask write; answers mask reads with a single reply.
// ----------------------------------------------------------------------------
// A write command (whole mask or one LED) produces 2*FRAME_MARK_BYTES +
// 4*NUM_LEDS result bytes, 40 at the default parameters, one per cycle from
// the back-end byte sequencer when the output is not stalled; a read produces
// one reply. The front end updates the mask and classifies each request in
// the cycle it is accepted, and a two-entry job queue lets it take up to two
// requests ahead of the frame in progress. Configuration writes are never
// held off (cfg_ready is always high) and must only be issued while the
// block is idle; indexes beyond the register list are ignored.
module led_strip_frame_serializer_unit import lsfs_pkg::*; #(
	parameter int NUM_LEDS         = 8,
	parameter int FRAME_MARK_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [2:0] led_index,
	input  logic       led_on,
	input  logic [7:0] mask_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_read_reply,
	output logic [7:0] read_value,
	output logic [7:0] frame_byte,
	output logic       frame_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t      cfg_q;
	q_status_t q_status;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_bright  <= ON_BRIGHT_RESET;
			cfg_q.off_bright <= OFF_BRIGHT_RESET;
			cfg_q.blue       <= LEVEL_RESET;
			cfg_q.green      <= LEVEL_RESET;
			cfg_q.red        <= LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ON_BRIGHT:  cfg_q.on_bright  <= cfg_data[4:0];
				REG_OFF_BRIGHT: cfg_q.off_bright <= cfg_data[4:0];
				REG_BLUE:       cfg_q.blue       <= cfg_data;
				REG_GREEN:      cfg_q.green      <= cfg_data;
				REG_RED:        cfg_q.red        <= cfg_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	lsfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.led_index  (led_index),
		.led_on     (led_on),
		.mask_value (mask_value),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	lsfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_status (q_status)
	);

	lsfs_back #(
		.NUM_LEDS         (NUM_LEDS),
		.FRAME_MARK_BYTES (FRAME_MARK_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_status      (q_status),
		.pop_job       (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_read_reply (is_read_reply),
		.read_value    (read_value),
		.frame_byte    (frame_byte),
		.frame_last    (frame_last)
	);

endmodule

@@ tb/sv/tb_led_strip_frame_serializer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_led_strip_frame_serializer_unit
// Self-checking bench for the LED strip frame serializer. Reads and mask
// writes are sent over the request channel, with random idling on both
// sides, and every frame byte or read reply is compared against a local
// model of the mask, the register set and the frame layout.
// ----------------------------------------------------------------------------
module tb_led_strip_frame_serializer_unit import lsfs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_LEDS         = 8;
	localparam int FRAME_MARK_BYTES = 4;
	localparam int STALL_LIMIT      = 3000;
	localparam int MAX_REPORTS      = 10;
	localparam int TAIL_CYCLES      = 60;
	localparam int HOLD_CYCLES      = 400;
	localparam int DIR_ROWS         = 20;

	// One accepted output item
	typedef struct packed {
		logic       is_rd;
		logic [7:0] rd_val;
		logic [7:0] fbyte;
		logic       last;
	} strip_out_t;

	typedef struct packed {
		cmd_t       op;
		logic [2:0] idx;
		logic       on;
		logic [7:0] mask;
		bit         typed;
		logic [7:0] typed_val;
	} dir_row_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [1:0] cmd        = 2'd0;
	logic [2:0] led_index  = 3'd0;
	logic       led_on     = 1'b0;
	logic [7:0] mask_value = 8'd0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       is_read_reply;
	logic [7:0] read_value;
	logic [7:0] frame_byte;
	logic       frame_last;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index  = 3'd0;
	logic [7:0] cfg_data   = 8'd0;

	// model state
	logic [7:0] strip_mask;
	cfg_t       reg_model;
	strip_out_t strip_out_q[$];

	int  mismatch_cnt  = 0;
	int  snd_idle_pct  = 0;
	int  rcv_idle_pct  = 0;
	int  rcv_hold_req  = 0;
	int  rcv_hold_left = 0;
	int  quiet_cycles  = 0;
	bit  snd_active    = 1'b0;

	// reads with a typed reply are checked against the literal value
	dir_row_t dir_tbl [0:DIR_ROWS-1] = '{
		'{CMD_RD_MASK, 3'd0, 1'b0, 8'h00, 1'b1, 8'hFF},
		'{CMD_RD_LED,  3'd0, 1'b0, 8'h00, 1'b1, 8'h01},
		'{CMD_RD_LED,  3'd7, 1'b0, 8'h00, 1'b1, 8'h01},
		'{CMD_WR_MASK, 3'd0, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{CMD_WR_MASK, 3'd0, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_RD_MASK, 3'd0, 1'b0, 8'h00, 1'b1, 8'h00},
		'{CMD_WR_LED,  3'd7, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_WR_LED,  3'd0, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_RD_MASK, 3'd0, 1'b0, 8'h00, 1'b1, 8'h81},
		'{CMD_RD_LED,  3'd7, 1'b0, 8'h00, 1'b1, 8'h01},
		'{CMD_RD_LED,  3'd3, 1'b0, 8'h00, 1'b1, 8'h00},
		'{CMD_WR_MASK, 3'd0, 1'b0, 8'hA5, 1'b0, 8'h00},
		'{CMD_WR_LED,  3'd5, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_WR_LED,  3'd2, 1'b1, 8'h00, 1'b0, 8'h00},
		'{CMD_WR_LED,  3'd6, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_RD_MASK, 3'd0, 1'b0, 8'h00, 1'b0, 8'h00},
		'{CMD_WR_MASK, 3'd6, 1'b1, 8'h5A, 1'b0, 8'h00},
		'{CMD_RD_LED,  3'd4, 1'b1, 8'hFF, 1'b0, 8'h00},
		'{CMD_WR_LED,  3'd1, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{CMD_RD_MASK, 3'd5, 1'b1, 8'h3C, 1'b0, 8'h00}
	};

	led_strip_frame_serializer_unit #(
		.NUM_LEDS        (NUM_LEDS),
		.FRAME_MARK_BYTES(FRAME_MARK_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.led_index    (led_index),
		.led_on       (led_on),
		.mask_value   (mask_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_read_reply(is_read_reply),
		.read_value   (read_value),
		.frame_byte   (frame_byte),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void queue_frame();
		logic [4:0] br;
		for (int k = 0; k < FRAME_MARK_BYTES; k++) begin
			strip_out_q.push_back('{1'b0, 8'h00, START_BYTE, 1'b0});
		end
		for (int i = NUM_LEDS - 1; i >= 0; i--) begin
			br = strip_mask[i] ? reg_model.on_bright : reg_model.off_bright;
			strip_out_q.push_back('{1'b0, 8'h00, BRIGHT_PREFIX | {3'b000, br}, 1'b0});
			strip_out_q.push_back('{1'b0, 8'h00, reg_model.blue, 1'b0});
			strip_out_q.push_back('{1'b0, 8'h00, reg_model.green, 1'b0});
			strip_out_q.push_back('{1'b0, 8'h00, reg_model.red, 1'b0});
		end
		for (int k = 0; k < FRAME_MARK_BYTES; k++) begin
			strip_out_q.push_back('{1'b0, 8'h00, END_BYTE, k == FRAME_MARK_BYTES - 1});
		end
	endfunction

	function automatic void predict_cmd(cmd_t op, logic [2:0] idx, logic on,
			logic [7:0] mask);
		case (op)
			CMD_WR_MASK: begin
				strip_mask = mask;
				queue_frame();
			end
			CMD_WR_LED: begin
				strip_mask[idx] = on;
				queue_frame();
			end
			CMD_RD_MASK: begin
				strip_out_q.push_back('{1'b1, strip_mask, 8'h00, 1'b0});
			end
			default: begin
				strip_out_q.push_back('{1'b1, {7'd0, strip_mask[idx]}, 8'h00, 1'b0});
			end
		endcase
	endfunction

	function automatic void latch_reg(logic [2:0] idx, logic [7:0] data);
		case (idx)
			REG_ON_BRIGHT:  reg_model.on_bright  = data[4:0];
			REG_OFF_BRIGHT: reg_model.off_bright = data[4:0];
			REG_BLUE:       reg_model.blue       = data;
			REG_GREEN:      reg_model.green      = data;
			REG_RED:        reg_model.red        = data;
			default: ;
		endcase
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		latch_reg(idx, data);
	endtask

	// Load all five registers, then poke one index past the register list
	task automatic load_regs(logic [7:0] on_b, logic [7:0] off_b, logic [7:0] blue,
			logic [7:0] green, logic [7:0] red, logic [2:0] junk_idx);
		write_reg(REG_ON_BRIGHT, on_b);
		write_reg(REG_OFF_BRIGHT, off_b);
		write_reg(REG_BLUE, blue);
		write_reg(REG_GREEN, green);
		write_reg(REG_RED, red);
		write_reg(junk_idx, 8'h5A ^ {junk_idx, junk_idx, junk_idx[1:0]});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_cmd(cmd_t op, logic [2:0] idx, logic on, logic [7:0] mask,
			bit typed, logic [7:0] typed_val);
		in_valid   <= 1'b1;
		cmd        <= op;
		led_index  <= idx;
		led_on     <= on;
		mask_value <= mask;
		snd_active = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (typed) begin
			strip_out_q.push_back('{1'b1, typed_val, 8'h00, 1'b0});
		end else begin
			predict_cmd(op, idx, on, mask);
		end
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			snd_active = 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
		end
	endtask

	task automatic send_random(bit writes_only);
		cmd_t op;
		op = writes_only ? cmd_t'($urandom_range(1)) : cmd_t'($urandom_range(3));
		send_cmd(op, 3'($urandom_range(7)), 1'($urandom_range(1)),
			8'($urandom_range(255)), 1'b0, 8'h00);
	endtask

	// Drop valid and hold until every predicted item has come out
	task automatic drain_requests();
		if (snd_active) begin
			in_valid <= 1'b0;
			snd_active = 1'b0;
		end
		while (strip_out_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (rcv_hold_req > 0) begin
			rcv_hold_left = rcv_hold_req;
			rcv_hold_req = 0;
		end
		if (rcv_hold_left > 0) begin
			out_ready <= 1'b0;
			rcv_hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		strip_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (strip_out_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0t: unexpected output rd=%0b val=%02h byte=%02h last=%0b",
						$realtime, is_read_reply, read_value, frame_byte, frame_last);
			end else begin
				want = strip_out_q.pop_front();
				if (is_read_reply !== want.is_rd || read_value !== want.rd_val ||
						frame_byte !== want.fbyte || frame_last !== want.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: exp rd=%0b val=%02h byte=%02h last=%0b, got rd=%0b val=%02h byte=%02h last=%0b",
							$realtime, want.is_rd, want.rd_val, want.fbyte, want.last,
							is_read_reply, read_value, frame_byte, frame_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		strip_mask = MASK_RESET;
		reg_model  = '{ON_BRIGHT_RESET, OFF_BRIGHT_RESET, LEVEL_RESET, LEVEL_RESET,
			LEVEL_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset register values
		snd_idle_pct = 33;
		rcv_idle_pct = 78;
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_cmd(dir_tbl[r].op, dir_tbl[r].idx, dir_tbl[r].on, dir_tbl[r].mask,
				dir_tbl[r].typed, dir_tbl[r].typed_val);
		end
		drain_requests();

		// full on, dark off; on brightness written too wide
		load_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 3'd5);
		for (int n = 0; n < 60; n++) send_random(1'b0);
		drain_requests();

		snd_idle_pct = 78;
		rcv_idle_pct = 33;
		load_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 3'd6);
		for (int n = 0; n < 60; n++) send_random(1'b0);
		drain_requests();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 3'd7);
		// stall the output and keep writing until the job queue backs up
		rcv_hold_req = HOLD_CYCLES;
		for (int n = 0; n < 6; n++) send_random(1'b1);
		drain_requests();
		for (int n = 0; n < 58; n++) send_random(1'b0);
		drain_requests();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && strip_out_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/lsfs_pkg.sv
sv/lsfs_front.sv
sv/lsfs_queue.sv
sv/lsfs_back.sv
sv/led_strip_frame_serializer_unit.sv
tb/sv/tb_led_strip_frame_serializer_unit.sv
